// File: rtl/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the streaming SHA-256 hasher
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// A property checked only while the block is out of reset.
`define SHS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sha256_stream_hasher: assertion failed");

// A property that is also checked across reset.
`define SHS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("sha256_stream_hasher: reset assertion failed");

`endif

// File: rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Beat types, round constants and initial hash values.
// ----------------------------------------------------------------------------
package shs_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } shs_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } shs_out_t;

    localparam logic SHS_CMD_ABSORB = 1'b0;
    localparam logic SHS_CMD_FINISH = 1'b1;

    localparam logic [2:0] SHS_LAST_INDEX = 3'd7;

    localparam logic [31:0] SHS_H_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHS_ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] SHS_PAD_MARK   = 8'h80;
    localparam logic [7:0] SHS_PAD_ZERO   = 8'h00;
    localparam logic [5:0] SHS_LEN_OFFSET = 6'd56;
    localparam logic [5:0] SHS_BLOCK_LAST = 6'd63;

endpackage

// File: rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// Streaming SHA-256 hasher
// Absorbs a message one byte per beat and returns the 256-bit digest as eight
// 32-bit word beats after a finish beat.
// ----------------------------------------------------------------------------
// The input channel carries one command per beat: an absorb beat appends a
// message byte, and a finish beat pads the message and starts the digest.
// The result channel returns eight beats per finish, word 0 first, with
// last_word set on the eighth.
// An absorb beat that completes a 64-byte block also starts the 64 rounds and
// the chaining update, during which s_ready is low; a single round unit
// performs one round per cycle.
// A finish beat writes the padding one byte per cycle, pausing while a full
// block is compressed (one or two compressions), then offers the digest words.
// s_ready is high only while the block is idle.
// While the receiver stalls, the current digest word is held unchanged.
// Synchronous reset returns the block to an empty message, idle and ready.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  shs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output shs_out_t m_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FINAL = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  fill_reg, fill_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        finishing_reg, finishing_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [31:0] chain_reg [0:7];
    logic [31:0] chain_next [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] v_next [0:7];
    logic [31:0] w_reg [0:15];
    logic [31:0] w_next [0:15];

    logic        push_en;
    logic [7:0]  push_data;
    logic [5:0]  fill_inc;
    logic [31:0] sum1, sum0, choose, major, t1, t2;
    logic [31:0] sig0, sig1, w_new;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign fill_inc = fill_reg + 6'd1;

    always_comb begin
        sum1   = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + sum1 + choose + SHS_ROUND_K[round_reg] + w_reg[0];
        sum0   = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = sum0 + major;
        sig0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new  = w_reg[0] + sig0 + w_reg[9] + sig1;
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        fill_next      = fill_reg;
        out_idx_next   = out_idx_reg;
        finishing_next = finishing_reg;
        bit_count_next = bit_count_reg;
        chain_next     = chain_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        push_en        = 1'b0;
        push_data      = SHS_PAD_ZERO;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.cmd == SHS_CMD_FINISH) begin
                        finishing_next = 1'b1;
                        phase_next     = PH_MARK;
                        state_next     = ST_PAD;
                    end else begin
                        bit_count_next = bit_count_reg + 64'd8;
                        push_en        = 1'b1;
                        push_data      = s_data.data_byte;
                    end
                end
            end
            ST_ROUND: begin
                for (int i = 7; i > 0; i--) begin
                    v_next[i] = v_reg[i-1];
                end
                v_next[4] = v_reg[3] + t1;
                v_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = w_new;
                round_next = round_reg + 6'd1;
                if (round_reg == SHS_BLOCK_LAST) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                if (!finishing_reg) begin
                    state_next = ST_IDLE;
                end else if (phase_reg == PH_DONE) begin
                    out_idx_next = 3'd0;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                case (phase_reg)
                    PH_MARK: begin
                        push_data  = SHS_PAD_MARK;
                        phase_next = (fill_inc == SHS_LEN_OFFSET) ? PH_LEN : PH_ZERO;
                    end
                    PH_ZERO: begin
                        push_data  = SHS_PAD_ZERO;
                        phase_next = (fill_inc == SHS_LEN_OFFSET) ? PH_LEN : PH_ZERO;
                    end
                    PH_LEN: begin
                        push_data      = bit_count_reg[63:56];
                        bit_count_next = {bit_count_reg[55:0], 8'h00};
                        phase_next     = (fill_reg == SHS_BLOCK_LAST) ? PH_DONE : PH_LEN;
                    end
                    default: begin
                        push_en = 1'b0;
                    end
                endcase
            end
            ST_OUT: begin
                if (m_ready) begin
                    for (int i = 0; i < 7; i++) begin
                        chain_next[i] = chain_reg[i+1];
                    end
                    chain_next[7] = SHS_H_INIT[out_idx_reg];
                    out_idx_next  = out_idx_reg + 3'd1;
                    if (out_idx_reg == SHS_LAST_INDEX) begin
                        bit_count_next = 64'd0;
                        fill_next      = 6'd0;
                        finishing_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en) begin
            for (int i = 0; i < 15; i++) begin
                w_next[i] = {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_next[15] = {w_reg[15][23:0], push_data};
            fill_next  = fill_inc;
            if (fill_reg == SHS_BLOCK_LAST) begin
                v_next     = chain_reg;
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MARK;
            round_reg     <= 6'd0;
            fill_reg      <= 6'd0;
            out_idx_reg   <= 3'd0;
            finishing_reg <= 1'b0;
            bit_count_reg <= 64'd0;
            chain_reg     <= SHS_H_INIT;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            fill_reg      <= fill_next;
            out_idx_reg   <= out_idx_next;
            finishing_reg <= finishing_next;
            bit_count_reg <= bit_count_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        m_data.digest_word = chain_reg[0];
        m_data.word_index  = out_idx_reg;
        m_data.last_word   = (out_idx_reg == SHS_LAST_INDEX);
    end

endmodule

// File: rtl/shs_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher port checker
// Watches the ports of the hasher and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module shs_checker
    import shs_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input shs_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input shs_out_t m_data
);

    // The block never takes a new command while digest words are pending.
    `SHS_ASSERT(a_no_overlap, !(s_ready && m_valid))

    `SHS_ASSERT(a_stall_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))

    `SHS_ASSERT(a_word_order, (m_valid && m_ready && !m_data.last_word) |=> (m_valid && (m_data.word_index == ($past(m_data.word_index) + 3'd1))))

    // After the final digest word the block is idle again.
    `SHS_ASSERT(a_last_idle, (m_valid && m_ready && m_data.last_word) |=> (s_ready && !m_valid))

    `SHS_ASSERT_RST(a_reset_idle, !aresetn |=> (s_ready && !m_valid))

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
